// ===== rtl/renc_pkg.sv =====
// Shared types, command codes and quadrature step table for the rotary encoder front end.
`timescale 1ns / 1ps

package renc_pkg;

  localparam int NUM_CHANNELS = 2;

  localparam logic [7:0] DEBOUNCE_RESET = 8'd6;
  localparam logic [6:0] DETENT_RESET   = 7'd4;
  localparam logic [7:0] LOW_RUN_MAX    = 8'd255;
  localparam logic [1:0] PHASE_RESET    = 2'b11;

  typedef enum logic [1:0] {
    CMD_ROTATE = 2'd0,
    CMD_BUTTON = 2'd1,
    CMD_SEED   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_DETENT   = 2'd1
  } reg_idx_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       channel;
    logic       phase_a;
    logic       phase_b;
    logic       switch_level;
  } item_t;

  typedef struct packed {
    logic [1:0]        last_phase;
    logic signed [7:0] step_total;
    logic [7:0]        low_run;
    logic              press_latched;
  } chan_state_t;

  typedef struct packed {
    logic signed [1:0] detent_step;
    logic              press_event;
  } result_t;

  typedef struct packed {
    logic [7:0] press_ticks;
    logic [6:0] detent_steps;
  } cfg_t;

  localparam logic signed [1:0] QUAD_STEP [16] = '{
     2'sd0, -2'sd1,  2'sd1,  2'sd0,
     2'sd1,  2'sd0,  2'sd0, -2'sd1,
    -2'sd1,  2'sd0,  2'sd0,  2'sd1,
     2'sd0,  2'sd1, -2'sd1,  2'sd0
  };

endpackage

// ===== rtl/rotary_encoder_input.sv =====
// Rotary encoder front end top level: input register, decode, result register, config.
// Pipeline: input register, then result register. Throughput: one item per cycle while
// out_stall is low; the per-channel state read, table lookup and add complete in the single
// decode stage, so back-to-back items on one channel chain.
// Reset: synchronous active low; channel state returns to phase 11 with cleared
// counters and latch, press threshold to 6, detent_steps to 4, both stages empty.
`timescale 1ns / 1ps

module rotary_encoder_input (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_cmd,
  input  logic              in_channel,
  input  logic              in_phase_a,
  input  logic              in_phase_b,
  input  logic              in_switch_level,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [1:0] out_detent_step,
  output logic              out_press_event,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data
);

  renc_pkg::cfg_t        cfg_r;
  renc_pkg::item_t       s1_item_r;
  logic                  s1_valid_r;
  renc_pkg::result_t     out_res_r;
  logic                  out_valid_r;
  logic                  advance;
  renc_pkg::chan_state_t cur_state;
  renc_pkg::chan_state_t nxt_state;
  logic                  step_wr;
  renc_pkg::result_t     step_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.press_ticks  <= renc_pkg::DEBOUNCE_RESET;
      cfg_r.detent_steps <= renc_pkg::DETENT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        renc_pkg::REG_DEBOUNCE: cfg_r.press_ticks  <= cfg_data;
        renc_pkg::REG_DETENT:   cfg_r.detent_steps <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= '{cmd: in_cmd, channel: in_channel, phase_a: in_phase_a,
                     phase_b: in_phase_b, switch_level: in_switch_level};
    end
  end

  renc_state u_state (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_channel (s1_item_r.channel),
    .rd_state   (cur_state),
    .wr_en      (s1_valid_r && advance && step_wr),
    .wr_channel (s1_item_r.channel),
    .wr_state   (nxt_state)
  );

  renc_step u_step (
    .item  (s1_item_r),
    .cur   (cur_state),
    .cfg   (cfg_r),
    .nxt   (nxt_state),
    .wr_en (step_wr),
    .res   (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_detent_step = out_res_r.detent_step;
  assign out_press_event = out_res_r.press_event;

`ifndef SYNTHESIS
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_item_r))
    else $error("input stage lost a held item");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_res_r))
    else $error("result register changed while stalled");

  a_det_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_res_r.detent_step != 2'sb10)
    else $error("invalid detent code");

  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_res_r.press_event && out_res_r.detent_step != 2'sd0))
    else $error("rotation and press event in one result");
`endif

endmodule

// ===== rtl/renc_state.sv =====
// Per-channel state storage with one read and one write port.
`timescale 1ns / 1ps

module renc_state (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  rd_channel,
  output renc_pkg::chan_state_t rd_state,
  input  logic                  wr_en,
  input  logic                  wr_channel,
  input  renc_pkg::chan_state_t wr_state
);

  renc_pkg::chan_state_t state_r [renc_pkg::NUM_CHANNELS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < renc_pkg::NUM_CHANNELS; i++) begin
        state_r[i].last_phase    <= renc_pkg::PHASE_RESET;
        state_r[i].step_total    <= '0;
        state_r[i].low_run       <= '0;
        state_r[i].press_latched <= 1'b0;
      end
    end else if (wr_en) begin
      state_r[wr_channel] <= wr_state;
    end
  end

  assign rd_state = state_r[rd_channel];

endmodule

// ===== rtl/renc_step.sv =====
// Decode one sample tick: quadrature step accumulation, button debounce and seeding.
`timescale 1ns / 1ps

module renc_step (
  input  renc_pkg::item_t       item,
  input  renc_pkg::chan_state_t cur,
  input  renc_pkg::cfg_t        cfg,
  output renc_pkg::chan_state_t nxt,
  output logic                  wr_en,
  output renc_pkg::result_t     res
);

  logic [1:0]        ab;
  logic signed [1:0] raw;
  logic signed [8:0] sum;
  logic signed [8:0] lim;
  logic [7:0]        run_nxt;
  logic              latch_nxt;
  logic              in_range;

  assign ab       = {item.phase_a, item.phase_b};
  assign raw      = renc_pkg::QUAD_STEP[{cur.last_phase, ab}];
  assign sum      = 9'(cur.step_total) + 9'(raw);
  assign lim      = $signed({2'b00, cfg.detent_steps});
  assign in_range = 32'(item.channel) < renc_pkg::NUM_CHANNELS;

  always_comb begin
    nxt             = cur;
    wr_en           = 1'b0;
    res.detent_step = 2'sd0;
    res.press_event = 1'b0;
    run_nxt         = cur.low_run;
    latch_nxt       = cur.press_latched;
    if (in_range) begin
      unique case (item.cmd)
        renc_pkg::CMD_SEED: begin
          wr_en              = 1'b1;
          nxt.last_phase     = ab;
          nxt.step_total     = '0;
          nxt.low_run        = '0;
          nxt.press_latched  = 1'b0;
        end
        renc_pkg::CMD_ROTATE: begin
          wr_en          = 1'b1;
          nxt.last_phase = ab;
          if (raw != 2'sd0) begin
            if (sum >= lim) begin
              nxt.step_total  = '0;
              res.detent_step = 2'sd1;
            end else if (sum <= -lim) begin
              nxt.step_total  = '0;
              res.detent_step = -2'sd1;
            end else begin
              nxt.step_total = sum[7:0];
            end
          end
        end
        renc_pkg::CMD_BUTTON: begin
          wr_en = 1'b1;
          if (!item.switch_level) begin
            if (cur.low_run != renc_pkg::LOW_RUN_MAX) begin
              run_nxt = cur.low_run + 8'd1;
            end
          end else begin
            run_nxt   = '0;
            latch_nxt = 1'b0;
          end
          if (run_nxt == cfg.press_ticks && !latch_nxt) begin
            latch_nxt       = 1'b1;
            res.press_event = 1'b1;
          end
          nxt.low_run       = run_nxt;
          nxt.press_latched = latch_nxt;
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

endmodule
